>>> rtl/dual_pin_bitstream_ring_player_defines.svh
// assertion macros shared by the ring player rtl
`ifndef DUAL_PIN_BITSTREAM_RING_PLAYER_DEFINES_SVH
`define DUAL_PIN_BITSTREAM_RING_PLAYER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define DRBP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define DRBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/drbp_pkg.sv
package drbp_pkg;

  // fixed field widths
  localparam int LEN_W      = 11;
  localparam int FREE_W     = 10;
  localparam int PAIR_W     = 2;
  localparam int LEN_RESET  = 1024;

  // command codes on the input tuser
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // short queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // pointer lanes of the modulo reducer
  localparam int PTR_LANES   = 3;
  localparam int LANE_READ   = 0;
  localparam int LANE_COMMIT = 1;
  localparam int LANE_STAGE  = 2;

  typedef enum logic {
    OP_WRITE,
    OP_TICK
  } op_t;

  // one classified beat waiting for the back end
  typedef struct packed {
    op_t               op;
    logic [PAIR_W-1:0] pair;
    logic              last;
  } item_t;

  // one result beat
  typedef struct packed {
    logic [FREE_W-1:0] free_slots;
    logic              overflow;
    logic              emitted;
    logic              pin_b;
    logic              pin_a;
  } result_t;

  // hold conditions seen by the front end
  typedef struct packed {
    logic clearing;
    logic mod_hold;
  } ctl_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FINISH
  } back_state_t;

endpackage

>>> rtl/ring_ram.sv
module ring_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/drbp_queue.sv
module drbp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  drbp_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            pop_valid,
  output drbp_pkg::item_t pop_item
);

  localparam int QW = (drbp_pkg::QUEUE_DEPTH > 1) ? $clog2(drbp_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(drbp_pkg::QUEUE_DEPTH + 1);

  drbp_pkg::item_t slots [drbp_pkg::QUEUE_DEPTH];
  logic [QW-1:0]   wr_ptr;
  logic [QW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full      = (count == CW'(drbp_pkg::QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_item  = slots[rd_ptr];

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QW'(drbp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QW'(drbp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/drbp_front.sv
module drbp_front (
  input  logic            rst,
  input  drbp_pkg::ctl_t  ctl,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [7:0]      s_tdata,
  input  logic            s_tuser,
  input  logic            s_tlast,
  input  logic            q_full,
  output logic            push,
  output drbp_pkg::item_t push_item
);

  // accept only when the back end can take new work
  assign s_tready = !rst && !ctl.clearing && !ctl.mod_hold && !q_full;
  assign push     = s_tvalid && s_tready;

  // classify the beat
  always_comb begin
    push_item.pair = s_tdata[drbp_pkg::PAIR_W-1:0];
    push_item.last = s_tlast;
    unique case (s_tuser)
      drbp_pkg::CMD_WRITE: push_item.op = drbp_pkg::OP_WRITE;
      drbp_pkg::CMD_TICK:  push_item.op = drbp_pkg::OP_TICK;
      default:             push_item.op = drbp_pkg::OP_TICK;
    endcase
  end

endmodule

>>> rtl/drbp_modred.sv
module drbp_modred #(
  parameter int MAX_DEPTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [$clog2(MAX_DEPTH+1)-1:0] n,
  input  logic [$clog2(MAX_DEPTH)-1:0] dividend [drbp_pkg::PTR_LANES],
  output logic                         busy,
  output logic                         done,
  output logic [$clog2(MAX_DEPTH)-1:0] rem [drbp_pkg::PTR_LANES]
);

  localparam int PW = $clog2(MAX_DEPTH);
  localparam int LW = $clog2(MAX_DEPTH + 1);
  localparam int RW = LW + 1;
  localparam int SW = $clog2(PW + 1);

  logic [PW-1:0] div_sh [drbp_pkg::PTR_LANES];
  logic [RW-1:0] part   [drbp_pkg::PTR_LANES];
  logic [RW-1:0] part_next [drbp_pkg::PTR_LANES];
  logic [SW-1:0] step;

  // one restoring step per lane: shift in a dividend bit, subtract if it fits
  always_comb begin
    for (int i = 0; i < drbp_pkg::PTR_LANES; i++) begin
      part_next[i] = {part[i][RW-2:0], div_sh[i][PW-1]};
      if (part_next[i] >= RW'(n)) begin
        part_next[i] = part_next[i] - RW'(n);
      end
      rem[i] = part[i][PW-1:0];
    end
  end

  // lane registers
  always_ff @(posedge clk) begin
    for (int i = 0; i < drbp_pkg::PTR_LANES; i++) begin
      if (start) begin
        div_sh[i] <= dividend[i];
        part[i]   <= '0;
      end else if (busy) begin
        div_sh[i] <= div_sh[i] << 1;
        part[i]   <= part_next[i];
      end
    end
  end

  // step counter, one bit of the dividend per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == SW'(PW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/drbp_back.sv
module drbp_back #(
  parameter int MAX_DEPTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [$clog2(MAX_DEPTH+1)-1:0] n,
  input  logic                           mod_hold,
  input  logic                           mod_done,
  input  logic [$clog2(MAX_DEPTH)-1:0]   mod_rem [drbp_pkg::PTR_LANES],
  output logic [$clog2(MAX_DEPTH)-1:0]   ptrs    [drbp_pkg::PTR_LANES],
  output logic                           clearing,
  input  logic                           q_valid,
  input  drbp_pkg::item_t                q_item,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output drbp_pkg::result_t              out_res
);

  localparam int PW = $clog2(MAX_DEPTH);
  localparam int LW = $clog2(MAX_DEPTH + 1);
  localparam int CW = PW + 1;
  localparam int FW = (PW + 2 > drbp_pkg::FREE_W) ? PW + 2 : drbp_pkg::FREE_W;

  drbp_pkg::back_state_t state, state_next;

  logic [PW-1:0] read_ptr, commit_ptr, stage_ptr;
  logic [PW-1:0] read_mod, commit_mod, stage_mod;
  logic [PW-1:0] clr_addr;
  logic [drbp_pkg::PAIR_W-1:0] pin_levels;
  logic          res_emitted, res_overflow;

  logic [PW-1:0] stage_adv, read_adv;
  logic          ring_full, can_play;
  logic          is_write;
  logic          ram_we;
  logic [PW-1:0] ram_waddr;
  logic [drbp_pkg::PAIR_W-1:0] ram_wdata, ram_rdata, pins_now;
  logic [FW-1:0] rr, ww, nn, free_full;

  // pointer advance with wrap at the ring length
  function automatic logic [PW-1:0] advance(input logic [PW-1:0] p,
                                            input logic [LW-1:0] len);
    logic [CW-1:0] q;
    q = {1'b0, p} + CW'(1);
    return (q >= CW'(len)) ? '0 : q[PW-1:0];
  endfunction

  assign ptrs[drbp_pkg::LANE_READ]   = read_ptr;
  assign ptrs[drbp_pkg::LANE_COMMIT] = commit_ptr;
  assign ptrs[drbp_pkg::LANE_STAGE]  = stage_ptr;
  assign clearing = (state == drbp_pkg::ST_CLEAR);

  // classify against the pointers
  assign stage_adv = advance(stage_ptr, n);
  assign read_adv  = advance(read_ptr, n);
  assign ring_full = (stage_adv == read_ptr);
  assign can_play  = (read_ptr != commit_ptr);
  assign is_write  = (q_item.op == drbp_pkg::OP_WRITE);

  // next state and pop
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    unique case (state)
      drbp_pkg::ST_CLEAR: begin
        if (clr_addr == PW'(MAX_DEPTH - 1)) begin
          state_next = drbp_pkg::ST_IDLE;
        end
      end
      drbp_pkg::ST_IDLE: begin
        if (q_valid && !mod_hold && (!out_valid || out_ready)) begin
          q_pop      = 1'b1;
          state_next = drbp_pkg::ST_FINISH;
        end
      end
      drbp_pkg::ST_FINISH: begin
        state_next = drbp_pkg::ST_IDLE;
      end
      default: state_next = drbp_pkg::ST_CLEAR;
    endcase
  end

  // store port: clearing sweep or staged write
  always_comb begin
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = q_pop && is_write && !ring_full;
      ram_waddr = stage_ptr;
      ram_wdata = q_item.pair;
    end
  end

  ring_ram #(
    .WIDTH (drbp_pkg::PAIR_W),
    .DEPTH (MAX_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (read_ptr),
    .rdata (ram_rdata)
  );

  // free slots from the reduced pointers, one slot kept empty
  always_comb begin
    rr = FW'(read_mod);
    ww = FW'(commit_mod);
    nn = FW'(n);
    if (rr > ww) begin
      free_full = rr - ww - FW'(1);
    end else begin
      free_full = rr + nn - ww - FW'(1);
    end
    pins_now = res_emitted ? ram_rdata : pin_levels;
  end

  // state register and clearing sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= drbp_pkg::ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // pointer updates
  always_ff @(posedge clk) begin
    if (rst) begin
      read_ptr   <= '0;
      commit_ptr <= '0;
      stage_ptr  <= '0;
      read_mod   <= '0;
      commit_mod <= '0;
      stage_mod  <= '0;
    end else if (mod_done) begin
      read_mod   <= mod_rem[drbp_pkg::LANE_READ];
      commit_mod <= mod_rem[drbp_pkg::LANE_COMMIT];
      stage_mod  <= mod_rem[drbp_pkg::LANE_STAGE];
    end else if (q_pop) begin
      if (is_write) begin
        if (!ring_full) begin
          stage_ptr <= stage_adv;
          stage_mod <= stage_adv;
        end
        if (q_item.last) begin
          commit_ptr <= ring_full ? stage_ptr : stage_adv;
          commit_mod <= ring_full ? stage_mod : stage_adv;
        end
      end else if (can_play) begin
        read_ptr <= read_adv;
        read_mod <= read_adv;
      end
    end
  end

  // per-item flags carried to the finish cycle
  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_emitted  <= !is_write && can_play;
      res_overflow <= is_write && ring_full;
    end
  end

  // pin levels and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      pin_levels <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (state == drbp_pkg::ST_FINISH) begin
        pin_levels <= pins_now;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == drbp_pkg::ST_FINISH) begin
      out_res.pin_a      <= pins_now[0];
      out_res.pin_b      <= pins_now[1];
      out_res.emitted    <= res_emitted;
      out_res.overflow   <= res_overflow;
      out_res.free_slots <= free_full[drbp_pkg::FREE_W-1:0];
    end
  end

endmodule

>>> rtl/dual_pin_bitstream_ring_player.sv
// Bit-pair ring player for two output pins.
// Input stream (s_*): one beat per command. tuser = 0 writes the pair in tdata
// into the staging slot, tlast on a write commits the staged batch to the
// player; tuser = 1 is a playback tick that plays the next committed pair.
// Output stream (m_*): exactly one result beat per input beat, in order, with
// the pin levels, emitted/overflow flags and the free slot count.
// Config: cfg_wr_en with cfg_wr_data sets the ring length (clamped to
// 2..MAX_DEPTH); write it only while no beat is in flight.
// Path: an accepted beat is registered in the queue, popped in the back end's
// idle state, finished around the registered store read in its finish state,
// then registered for m_tvalid; the back end pops a new beat only from idle.
// A config write holds s_tready low while the pointers are reduced modulo the
// new length, one bit a cycle.
// Reset: synchronous; afterwards a clearing sweep zeroes the pair store
// with s_tready low, config writes still taken.
// Stall: the result register holds while m_tready is low; a two-beat queue
// keeps accepting until full, then s_tready drops.
`include "dual_pin_bitstream_ring_player_defines.svh"

module dual_pin_bitstream_ring_player #(
  parameter int MAX_DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [drbp_pkg::LEN_W-1:0] cfg_wr_data,  // ring_length
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,      // bit_a, bit_b, zero pad
  input  logic                       s_tuser,      // command
  input  logic                       s_tlast,      // end_of_batch
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [15:0]                m_tdata       // pin_a, pin_b, emitted, overflow,
                                                   // free_slots[9:0], zero pad
);

  localparam int PW = $clog2(MAX_DEPTH);
  localparam int LW = $clog2(MAX_DEPTH + 1);
  localparam int EW = (LW > drbp_pkg::LEN_W) ? LW : drbp_pkg::LEN_W;

  logic [drbp_pkg::LEN_W-1:0] ring_length;
  logic [EW-1:0]              len_ext;
  logic [LW-1:0]              n;
  logic                       cfg_pend;
  logic                       mod_busy, mod_done;
  logic [PW-1:0]              mod_rem [drbp_pkg::PTR_LANES];
  logic [PW-1:0]              ptrs    [drbp_pkg::PTR_LANES];
  logic                       clearing;
  drbp_pkg::ctl_t             ctl;
  logic                       push, q_full, q_pop, q_valid;
  drbp_pkg::item_t            push_item, q_item;
  drbp_pkg::result_t          out_res;

  // ring length register and pending reduction flag
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_length <= drbp_pkg::LEN_W'(drbp_pkg::LEN_RESET);
      cfg_pend    <= 1'b0;
    end else begin
      cfg_pend <= cfg_wr_en;
      if (cfg_wr_en) begin
        ring_length <= cfg_wr_data;
      end
    end
  end

  // effective length, clamped
  always_comb begin
    len_ext = EW'(ring_length);
    if (len_ext > EW'(MAX_DEPTH)) begin
      n = LW'(MAX_DEPTH);
    end else if (len_ext < EW'(2)) begin
      n = LW'(2);
    end else begin
      n = LW'(len_ext);
    end
  end

  assign ctl.clearing = clearing;
  assign ctl.mod_hold = cfg_pend || mod_busy || mod_done;

  drbp_front u_front (
    .rst       (rst),
    .ctl       (ctl),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  drbp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (q_item)
  );

  drbp_modred #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_modred (
    .clk      (clk),
    .rst      (rst),
    .start    (cfg_pend),
    .n        (n),
    .dividend (ptrs),
    .busy     (mod_busy),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  drbp_back #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .n         (n),
    .mod_hold  (ctl.mod_hold),
    .mod_done  (mod_done),
    .mod_rem   (mod_rem),
    .ptrs      (ptrs),
    .clearing  (clearing),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  // result beat packing
  assign m_tdata = {2'b00, out_res.free_slots, out_res.overflow, out_res.emitted,
                    out_res.pin_b, out_res.pin_a};

  // checks
  `DRBP_ASSERT_NOW(a_no_accept_clearing, clearing, !s_tready, "beat accepted during clear")
  `DRBP_ASSERT_NEXT(a_cfg_blocks_input, cfg_wr_en, !s_tready, "beat accepted after cfg write")
  `DRBP_ASSERT_NOW(a_flags_exclusive, m_tvalid, !(m_tdata[2] && m_tdata[3]),
                   "emitted and overflow both set")

endmodule

>>> test/testbench.sv
module testbench;

  localparam int RING_SLOTS = 1024;
  localparam int HOLD_AT_BEAT = 700;
  localparam int HOLD_CYCLES = 400;

  // directed plan: item rows, ring length rows, optional typed-in result
  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_TICK,
    ROW_LEN
  } row_kind_t;

  typedef struct packed {
    row_kind_t                  kind;
    logic                       a;
    logic                       b;
    logic                       last;
    logic [drbp_pkg::LEN_W-1:0] len;
    logic                       typed;
    drbp_pkg::result_t          want;
  } plan_row_t;

  localparam int PLAN_ROWS = 28;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // empty ring after reset, one two-pair batch, played out, then empty again
    '{ROW_TICK,  1'b0, 1'b0, 1'b0, 11'd0, 1'b1, '{10'd1023, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{ROW_WRITE, 1'b1, 1'b0, 1'b0, 11'd0, 1'b1, '{10'd1023, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{ROW_WRITE, 1'b0, 1'b1, 1'b1, 11'd0, 1'b1, '{10'd1021, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{ROW_TICK,  1'b0, 1'b0, 1'b0, 11'd0, 1'b1, '{10'd1022, 1'b0, 1'b1, 1'b0, 1'b1}},
    '{ROW_TICK,  1'b0, 1'b0, 1'b0, 11'd0, 1'b1, '{10'd1023, 1'b0, 1'b1, 1'b1, 1'b0}},
    '{ROW_TICK,  1'b1, 1'b1, 1'b1, 11'd0, 1'b1, '{10'd1023, 1'b0, 1'b0, 1'b1, 1'b0}},
    // length below the minimum, pointers left past the new length
    '{ROW_LEN,   1'b0, 1'b0, 1'b0, 11'd1, 1'b0, '0},
    '{ROW_WRITE, 1'b1, 1'b1, 1'b1, 11'd0, 1'b0, '0},
    '{ROW_WRITE, 1'b0, 1'b0, 1'b0, 11'd0, 1'b0, '0},
    '{ROW_WRITE, 1'b1, 1'b0, 1'b1, 11'd0, 1'b0, '0},
    '{ROW_TICK,  1'b0, 1'b0, 1'b0, 11'd0, 1'b0, '0},
    '{ROW_TICK,  1'b0, 1'b0, 1'b0, 11'd0, 1'b0, '0},
    '{ROW_WRITE, 1'b0, 1'b1, 1'b0, 11'd0, 1'b0, '0},
    // write into a full ring with commit still taking place
    '{ROW_WRITE, 1'b1, 1'b1, 1'b1, 11'd0, 1'b1, '{10'd0, 1'b1, 1'b0, 1'b1, 1'b1}},
    '{ROW_TICK,  1'b0, 1'b0, 1'b0, 11'd0, 1'b1, '{10'd1, 1'b0, 1'b1, 1'b1, 1'b0}},
    // length above the maximum
    '{ROW_LEN,   1'b0, 1'b0, 1'b0, 11'd2047, 1'b0, '0},
    '{ROW_WRITE, 1'b1, 1'b1, 1'b0, 11'd0, 1'b0, '0},
    '{ROW_WRITE, 1'b0, 1'b0, 1'b1, 11'd0, 1'b0, '0},
    '{ROW_TICK,  1'b0, 1'b0, 1'b0, 11'd0, 1'b0, '0},
    '{ROW_TICK,  1'b0, 1'b0, 1'b0, 11'd0, 1'b0, '0},
    '{ROW_TICK,  1'b0, 1'b0, 1'b0, 11'd0, 1'b0, '0},
    // zero length acts as the minimum
    '{ROW_LEN,   1'b0, 1'b0, 1'b0, 11'd0, 1'b0, '0},
    '{ROW_WRITE, 1'b1, 1'b0, 1'b1, 11'd0, 1'b0, '0},
    '{ROW_TICK,  1'b0, 1'b0, 1'b0, 11'd0, 1'b0, '0},
    '{ROW_WRITE, 1'b0, 1'b1, 1'b0, 11'd0, 1'b0, '0},
    '{ROW_WRITE, 1'b1, 1'b1, 1'b1, 11'd0, 1'b0, '0},
    '{ROW_TICK,  1'b0, 1'b0, 1'b0, 11'd0, 1'b0, '0},
    '{ROW_LEN,   1'b0, 1'b0, 1'b0, 11'd1024, 1'b0, '0}
  };

  logic                       clk;
  logic                       rst;
  logic                       cfg_wr_en;
  logic [drbp_pkg::LEN_W-1:0] cfg_wr_data;
  logic                       s_tvalid;
  logic                       s_tready;
  logic [7:0]                 s_tdata;   // bit_a, bit_b, zero pad
  logic                       s_tuser;   // command
  logic                       s_tlast;   // end_of_batch
  logic                       m_tvalid;
  logic                       m_tready;
  logic [15:0]                m_tdata;   // pin_a, pin_b, emitted, overflow, free_slots, zero pad

  // shadow copy of the player state
  logic [drbp_pkg::PAIR_W-1:0] pair_mem [RING_SLOTS];
  int unsigned                 rd_ptr;
  int unsigned                 cm_ptr;
  int unsigned                 st_ptr;
  logic [drbp_pkg::PAIR_W-1:0] pins;
  logic [drbp_pkg::LEN_W-1:0]  ring_len;

  drbp_pkg::result_t pin_reports [$];
  int                fail_count;
  int                sent_beats;
  int                n_writes;
  int                n_ticks;
  int                n_dropped;
  int                n_played;
  int                n_lengths;

  dual_pin_bitstream_ring_player i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  initial begin
    #20000000;
    $display("dual_pin_bitstream_ring_player verification failed");
    $finish;
  end

  // back-to-back stretches (40 of every 160 beats), random gaps otherwise
  function automatic int pick_gap(input int seq);
    return ((seq / 40) % 4 == 1) ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic logic rbit();
    return 1'($urandom_range(0, 1));
  endfunction

  // advance a pointer with wrap at the effective length
  function automatic int unsigned wrap_next(input int unsigned p, input int unsigned n);
    return (p + 1 >= n) ? 0 : p + 1;
  endfunction

  // one input beat through the shadow player, returns the expected result
  function automatic drbp_pkg::result_t play_step(input logic cmd, input logic a,
                                                  input logic b, input logic last);
    int unsigned       n;
    int unsigned       nxt;
    int unsigned       rr;
    int unsigned       ww;
    drbp_pkg::result_t r;
    n = ring_len;
    if (n < 2) n = 2;
    if (n > RING_SLOTS) n = RING_SLOTS;
    r = '0;
    if (cmd == drbp_pkg::CMD_WRITE) begin
      n_writes++;
      nxt = wrap_next(st_ptr, n);
      if (nxt == rd_ptr) begin
        r.overflow = 1'b1;
        n_dropped++;
      end else begin
        pair_mem[st_ptr] = {b, a};
        st_ptr = nxt;
      end
      if (last) cm_ptr = st_ptr;
    end else begin
      n_ticks++;
      if (rd_ptr != cm_ptr) begin
        pins = pair_mem[rd_ptr];
        rd_ptr = wrap_next(rd_ptr, n);
        r.emitted = 1'b1;
        n_played++;
      end
    end
    rr = rd_ptr % n;
    ww = cm_ptr % n;
    r.free_slots = drbp_pkg::FREE_W'((rr + n - ww - 1) % n);
    r.pin_a = pins[0];
    r.pin_b = pins[1];
    return r;
  endfunction

  // offer one beat, wait for acceptance, then queue its expected result
  task automatic offer(input logic cmd, input logic a, input logic b, input logic last,
                       input logic typed = 1'b0, input drbp_pkg::result_t want = '0);
    int                gap;
    drbp_pkg::result_t r;
    gap = pick_gap(sent_beats);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, b, a};
    s_tuser  <= cmd;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    sent_beats++;
    r = play_step(cmd, a, b, last);
    pin_reports.push_back(typed ? want : r);
  endtask

  // stop offering and let every expected result come out
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pin_reports.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_length(input logic [drbp_pkg::LEN_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    ring_len = v;
    n_lengths++;
  endtask

  // random batches of writes, most closed by a commit, runs of ticks, some noise
  task automatic run_phase(input int budget, input int tick_run);
    int   sent;
    int   k;
    int   nb;
    int   nt;
    logic close;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 9) == 0) begin
        offer(rbit(), rbit(), rbit(), rbit());
        sent++;
      end else begin
        nb = $urandom_range(1, 24);
        close = ($urandom_range(0, 7) != 0);
        for (k = 0; k < nb; k++) begin
          offer(drbp_pkg::CMD_WRITE, rbit(), rbit(), close && (k == nb - 1));
        end
        nt = $urandom_range(1, tick_run);
        for (k = 0; k < nt; k++) offer(drbp_pkg::CMD_TICK, rbit(), rbit(), rbit());
        sent += nb + nt;
      end
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // result side: random stalls, one long hold to fill the block
  initial begin : result_sink
    int                gap;
    int                seen;
    drbp_pkg::result_t got;
    drbp_pkg::result_t want;
    seen = 0;
    m_tready <= 1'b0;
    do @(posedge clk); while (rst);
    gap = pick_gap(seen);
    forever begin
      if (gap == 0) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
        m_tready <= 1'b1;
      end
      do @(posedge clk); while (!m_tvalid);
      got = drbp_pkg::result_t'(m_tdata[13:0]);
      if (pin_reports.size() == 0) begin
        $error("result beat with no expected result pending");
        fail_count++;
      end else begin
        want = pin_reports.pop_front();
        check_field("pin_a", want.pin_a, got.pin_a);
        check_field("pin_b", want.pin_b, got.pin_b);
        check_field("emitted", want.emitted, got.emitted);
        check_field("overflow", want.overflow, got.overflow);
        check_field("free_slots", want.free_slots, got.free_slots);
      end
      seen++;
      gap = (seen == HOLD_AT_BEAT) ? HOLD_CYCLES : pick_gap(seen);
    end
  end

  // stimulus
  initial begin : stimulus
    int i;
    int p;
    rst         <= 1'b1;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    s_tvalid    <= 1'b0;
    s_tdata     <= '0;
    s_tuser     <= drbp_pkg::CMD_WRITE;
    s_tlast     <= 1'b0;
    for (i = 0; i < RING_SLOTS; i++) pair_mem[i] = '0;
    rd_ptr = 0;
    cm_ptr = 0;
    st_ptr = 0;
    pins = '0;
    ring_len = drbp_pkg::LEN_W'(drbp_pkg::LEN_RESET);
    fail_count = 0;
    sent_beats = 0;
    n_writes = 0;
    n_ticks = 0;
    n_dropped = 0;
    n_played = 0;
    n_lengths = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed part
    for (i = 0; i < PLAN_ROWS; i++) begin
      case (PLAN[i].kind)
        ROW_LEN: begin
          settle();
          set_length(PLAN[i].len);
        end
        ROW_WRITE: begin
          offer(drbp_pkg::CMD_WRITE, PLAN[i].a, PLAN[i].b, PLAN[i].last,
                PLAN[i].typed, PLAN[i].want);
        end
        default: begin
          offer(drbp_pkg::CMD_TICK, PLAN[i].a, PLAN[i].b, PLAN[i].last,
                PLAN[i].typed, PLAN[i].want);
        end
      endcase
    end

    // random phases, each at its own ring length
    for (p = 0; p < 8; p++) begin
      settle();
      case (p)
        0: set_length(drbp_pkg::LEN_W'(3));
        1: set_length(drbp_pkg::LEN_W'($urandom_range(2, 40)));
        2: set_length(drbp_pkg::LEN_W'(1024));
        3: set_length(drbp_pkg::LEN_W'($urandom_range(0, 2047)));
        4: set_length(drbp_pkg::LEN_W'(2));
        5: set_length(drbp_pkg::LEN_W'($urandom_range(2, 64)));
        6: set_length(drbp_pkg::LEN_W'(1023));
        default: set_length(drbp_pkg::LEN_W'($urandom_range(4, 20)));
      endcase
      run_phase(250, (p % 2 == 1) ? 6 : 16);
    end

    settle();
    $display("run covered %0d writes (%0d dropped on a full ring) and %0d ticks (%0d played)",
             n_writes, n_dropped, n_ticks, n_played);
    $display("across %0d ring length settings, including both clamped ends", n_lengths);
    if (fail_count == 0) begin
      $display("dual_pin_bitstream_ring_player verification clean");
    end else begin
      $display("dual_pin_bitstream_ring_player verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/drbp_pkg.sv
rtl/ring_ram.sv
rtl/drbp_queue.sv
rtl/drbp_front.sv
rtl/drbp_modred.sv
rtl/drbp_back.sv
rtl/dual_pin_bitstream_ring_player.sv
test/testbench.sv
